// ===== hdl/sbgw_pkg.sv =====
package sbgw_pkg;

    localparam int BLOCK_SIZE_DEF = 8;
    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int QUEUE_DEPTH    = 4;

    // widest store address and block index over the parameter range
    localparam int ADDR_MAX_W = 22;
    localparam int BLK_MAX_W  = 16;

    localparam int WORKER_W = 8;
    localparam int BLOCKS_W = 11;
    localparam int TBLK_W   = 10;
    localparam int SLOT_W   = 6;
    localparam int BITS_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 11;

    localparam logic [BLOCKS_W-1:0] BLOCKS_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_WORKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 1'b1;

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_RECV = 2'd1,
        FUNC_SEND = 2'd2
    } t_func;

    typedef struct packed {
        t_func                 func;
        logic                  wr_ok;
        logic [ADDR_MAX_W-1:0] addr;
        logic [BLK_MAX_W-1:0]  blk;
        logic [SLOT_W-1:0]     slot;
        logic [BITS_W-1:0]     bits;
        logic [BLOCKS_W-1:0]   follow;
        logic                  last;
    } t_cmd;

    typedef struct packed {
        logic                sent;
        logic [WORKER_W-1:0] sender;
        logic [BLOCKS_W-1:0] sent_block;
        logic [SLOT_W-1:0]   sent_slot;
        logic [BITS_W-1:0]   sent_bits;
        logic [BLOCKS_W-1:0] next_nonzero_block;
        logic                run_end;
    } t_res;

endpackage

// ===== hdl/sparse_block_gradient_worker.sv =====
// Block-sparse gradient worker. Items enter through a queue-style port
// (push/full) and results leave through one (empty/pop). The back end handles
// load and receive requests in its idle state. A send request that is due
// scans the per-element nonzero flag rows at one block per cycle from the
// block after the wanted one up to the block limit (stopping at the first
// nonzero block), then emits the wanted block element by element through the
// single store read port, each element in a read then a write state; the write
// state waits while the result queue is full. A send that is not due gives one
// result. A clearing pass after reset zeroes the store, with full held high.
module sparse_block_gradient_worker #(
    parameter int BLOCK_SIZE = sbgw_pkg::BLOCK_SIZE_DEF,
    parameter int MAX_BLOCKS = sbgw_pkg::MAX_BLOCKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     i_func,
    input  logic [sbgw_pkg::TBLK_W-1:0]    i_target_block,
    input  logic [sbgw_pkg::SLOT_W-1:0]    i_slot,
    input  logic [sbgw_pkg::BITS_W-1:0]    i_element_bits,
    input  logic [sbgw_pkg::BLOCKS_W-1:0]  i_following_block,
    input  logic                           i_final_element,
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_sent,
    output logic [sbgw_pkg::WORKER_W-1:0]  o_sender,
    output logic [sbgw_pkg::BLOCKS_W-1:0]  o_sent_block,
    output logic [sbgw_pkg::SLOT_W-1:0]    o_sent_slot,
    output logic [sbgw_pkg::BITS_W-1:0]    o_sent_bits,
    output logic [sbgw_pkg::BLOCKS_W-1:0]  o_next_nonzero_block,
    output logic                           o_run_end,
    input  logic                           i_cfg_we,
    input  logic [sbgw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sbgw_pkg::CFG_W-1:0]     i_cfg_data
);
    logic [sbgw_pkg::WORKER_W-1:0] r_worker;
    logic [sbgw_pkg::BLOCKS_W-1:0] r_blocks;

    sbgw_pkg::t_cmd front_cmd, back_cmd;
    sbgw_pkg::t_res back_res, out_res;
    logic           front_push, cmd_full, cmd_empty, cmd_pop;
    logic           res_push, res_full, clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_worker <= '0;
            r_blocks <= sbgw_pkg::BLOCKS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sbgw_pkg::CFG_WORKER: r_worker <= i_cfg_data[sbgw_pkg::WORKER_W-1:0];
                sbgw_pkg::CFG_BLOCKS: r_blocks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sbgw_front #(.BLOCK_SIZE(BLOCK_SIZE), .MAX_BLOCKS(MAX_BLOCKS)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_hold            (clearing),
        .i_push            (push),
        .o_full            (full),
        .i_func            (i_func),
        .i_target_block    (i_target_block),
        .i_slot            (i_slot),
        .i_element_bits    (i_element_bits),
        .i_following_block (i_following_block),
        .i_final_element   (i_final_element),
        .o_cmd_push        (front_push),
        .o_cmd             (front_cmd),
        .i_cmd_full        (cmd_full)
    );

    sbgw_fifo #(.WIDTH($bits(sbgw_pkg::t_cmd)), .DEPTH(sbgw_pkg::QUEUE_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    sbgw_back #(.BLOCK_SIZE(BLOCK_SIZE), .MAX_BLOCKS(MAX_BLOCKS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (back_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res),
        .i_worker    (r_worker),
        .i_blocks    (r_blocks),
        .o_clearing  (clearing)
    );

    sbgw_fifo #(.WIDTH($bits(sbgw_pkg::t_res)), .DEPTH(sbgw_pkg::QUEUE_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_sent               = out_res.sent;
    assign o_sender             = out_res.sender;
    assign o_sent_block         = out_res.sent_block;
    assign o_sent_slot          = out_res.sent_slot;
    assign o_sent_bits          = out_res.sent_bits;
    assign o_next_nonzero_block = out_res.next_nonzero_block;
    assign o_run_end            = out_res.run_end;
endmodule

// ===== hdl/sbgw_fifo.sv =====
module sbgw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sbgw_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_rd, r_wr;
    logic [PW:0]      r_cnt;
    logic             wr, rd;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push & ~o_full;
    assign rd      = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wr <= (r_wr == PW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (rd) begin
                r_rd <= (r_rd == PW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(wr) - (PW+1)'(rd);
        end
    end
endmodule

// ===== hdl/sbgw_front.sv =====
module sbgw_front #(
    parameter int BLOCK_SIZE = sbgw_pkg::BLOCK_SIZE_DEF,
    parameter int MAX_BLOCKS = sbgw_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_hold,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [1:0]                    i_func,
    input  logic [sbgw_pkg::TBLK_W-1:0]   i_target_block,
    input  logic [sbgw_pkg::SLOT_W-1:0]   i_slot,
    input  logic [sbgw_pkg::BITS_W-1:0]   i_element_bits,
    input  logic [sbgw_pkg::BLOCKS_W-1:0] i_following_block,
    input  logic                          i_final_element,
    output logic                          o_cmd_push,
    output sbgw_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_full
);
    logic           r_valid;
    sbgw_pkg::t_cmd r_cmd;
    sbgw_pkg::t_cmd n_cmd;
    logic           known;
    logic [31:0]    addr_full;

    assign o_full     = i_hold | (r_valid & i_cmd_full);
    assign o_cmd_push = r_valid;
    assign o_cmd      = r_cmd;

    // unused function code is dropped here and never reaches the back end
    assign known = (i_func == sbgw_pkg::FUNC_LOAD) || (i_func == sbgw_pkg::FUNC_RECV)
                || (i_func == sbgw_pkg::FUNC_SEND);
    assign addr_full = 32'(i_target_block) * 32'(BLOCK_SIZE) + 32'(i_slot);

    always_comb begin
        n_cmd        = '0;
        n_cmd.func   = sbgw_pkg::t_func'(i_func);
        n_cmd.wr_ok  = (32'(i_target_block) < 32'(MAX_BLOCKS)) && (32'(i_slot) < 32'(BLOCK_SIZE));
        n_cmd.addr   = addr_full[sbgw_pkg::ADDR_MAX_W-1:0];
        n_cmd.blk    = sbgw_pkg::BLK_MAX_W'(i_target_block);
        n_cmd.slot   = i_slot;
        n_cmd.bits   = i_element_bits;
        n_cmd.follow = i_following_block;
        n_cmd.last   = i_final_element;
    end

    always_ff @(posedge i_clk) begin
        if (!o_full) begin
            r_cmd <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_full) begin
            r_valid <= i_push & known;
        end
    end
endmodule

// ===== hdl/sbgw_back.sv =====
module sbgw_back #(
    parameter int BLOCK_SIZE = sbgw_pkg::BLOCK_SIZE_DEF,
    parameter int MAX_BLOCKS = sbgw_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sbgw_pkg::t_cmd                i_cmd,
    input  logic                          i_cmd_empty,
    output logic                          o_cmd_pop,
    input  logic                          i_res_full,
    output logic                          o_res_push,
    output sbgw_pkg::t_res                o_res,
    input  logic [sbgw_pkg::WORKER_W-1:0] i_worker,
    input  logic [sbgw_pkg::BLOCKS_W-1:0] i_blocks,
    output logic                          o_clearing
);
    localparam int DEPTH = MAX_BLOCKS * BLOCK_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NZ_AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int BLK_W = $clog2(MAX_BLOCKS + 1);
    localparam int CW    = (BLK_W > sbgw_pkg::BLOCKS_W) ? BLK_W : sbgw_pkg::BLOCKS_W;
    localparam int SW    = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_RD    = 5'b01000,
        ST_WR    = 5'b10000
    } t_state;

    logic [sbgw_pkg::BITS_W-1:0] r_data [DEPTH];
    logic [BLOCK_SIZE-1:0]       r_nz   [MAX_BLOCKS];
    logic [sbgw_pkg::BITS_W-1:0] r_data_q;
    logic [BLOCK_SIZE-1:0]       r_nz_q;

    t_state                        r_state;
    logic [AW-1:0]                 r_clr;
    logic [sbgw_pkg::BLOCKS_W-1:0] r_wanted, r_own, r_blk;
    logic [CW-1:0]                 r_scan, r_pend_blk;
    logic                          r_pend;
    logic [AW-1:0]                 r_addr;
    logic [SW-1:0]                 r_cnt;

    logic [CW-1:0] limit;
    logic          due, take, is_send, found, last_el, elem_wr;
    logic [31:0]   base_full;

    assign limit   = (CW'(i_blocks) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(i_blocks);
    assign due     = (r_wanted == r_own) && (CW'(r_wanted) < limit);
    assign take    = (r_state == ST_IDLE) && !i_cmd_empty && !i_res_full;
    assign is_send = (i_cmd.func == sbgw_pkg::FUNC_SEND);
    assign found   = r_pend && (|r_nz_q);
    assign last_el = (r_cnt == SW'(BLOCK_SIZE-1));
    assign elem_wr = take && !is_send && i_cmd.wr_ok;
    assign base_full = 32'(r_wanted) * 32'(BLOCK_SIZE);

    assign o_cmd_pop  = take;
    assign o_clearing = (r_state == ST_CLEAR);
    assign o_res_push = ((r_state == ST_WR) && !i_res_full) || (take && is_send && !due);

    always_comb begin
        o_res = '0;
        if (r_state == ST_WR) begin
            o_res.sent               = 1'b1;
            o_res.sender             = i_worker;
            o_res.sent_block         = r_blk;
            o_res.sent_slot          = sbgw_pkg::SLOT_W'(r_cnt);
            o_res.sent_bits          = r_data_q;
            o_res.next_nonzero_block = r_own;
            o_res.run_end            = last_el;
        end else begin
            o_res.run_end = 1'b1;
        end
    end

    // element store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_data[r_clr] <= '0;
        end else if (elem_wr) begin
            r_data[i_cmd.addr[AW-1:0]] <= i_cmd.bits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data_q <= r_data[r_addr];
    end

    // per-element nonzero flags, one row per block, both zeros count as zero
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            if (32'(r_clr) < 32'(MAX_BLOCKS)) begin
                r_nz[r_clr[NZ_AW-1:0]] <= '0;
            end
        end else if (elem_wr) begin
            r_nz[i_cmd.blk[NZ_AW-1:0]][i_cmd.slot[SW-1:0]] <= |i_cmd.bits[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_nz_q <= r_nz[r_scan[NZ_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_wanted <= '0;
            r_own    <= '0;
            r_pend   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH-1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (take) begin
                        unique case (i_cmd.func)
                            sbgw_pkg::FUNC_RECV: begin
                                if (i_cmd.last) begin
                                    r_wanted <= i_cmd.follow;
                                end
                            end
                            sbgw_pkg::FUNC_SEND: begin
                                if (due) begin
                                    r_blk   <= r_wanted;
                                    r_scan  <= CW'(r_wanted) + 1'b1;
                                    r_pend  <= 1'b0;
                                    r_addr  <= base_full[AW-1:0];
                                    r_cnt   <= '0;
                                    r_state <= ST_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    // one flag row read per cycle, checked once registered
                    if (found) begin
                        r_own   <= sbgw_pkg::BLOCKS_W'(r_pend_blk);
                        r_state <= ST_RD;
                    end else if (r_scan >= limit) begin
                        r_own   <= sbgw_pkg::BLOCKS_W'(MAX_BLOCKS);
                        r_state <= ST_RD;
                    end else begin
                        r_pend     <= 1'b1;
                        r_pend_blk <= r_scan;
                        r_scan     <= r_scan + 1'b1;
                    end
                end
                ST_RD: begin
                    r_state <= ST_WR;
                end
                ST_WR: begin
                    if (!i_res_full) begin
                        if (last_el) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_addr  <= r_addr + 1'b1;
                            r_state <= ST_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== hdl/sbgw_checker.sv =====
module sbgw_checker #(
    parameter int BLOCK_SIZE = sbgw_pkg::BLOCK_SIZE_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic                          o_sent,
    input logic [sbgw_pkg::WORKER_W-1:0] o_sender,
    input logic [sbgw_pkg::BLOCKS_W-1:0] o_sent_block,
    input logic [sbgw_pkg::SLOT_W-1:0]   o_sent_slot,
    input logic [sbgw_pkg::BITS_W-1:0]   o_sent_bits,
    input logic [sbgw_pkg::BLOCKS_W-1:0] o_next_nonzero_block,
    input logic                          o_run_end
);
    // a refused send is a single all-zero result that closes its run
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_sent) |-> (o_run_end && o_sender == '0 && o_sent_block == '0
            && o_sent_slot == '0 && o_sent_bits == '0 && o_next_nonzero_block == '0))
        else $error("refused send result not clean");

    a_run_end_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_sent) |-> (o_run_end == (o_sent_slot == sbgw_pkg::SLOT_W'(BLOCK_SIZE-1))))
        else $error("run end not on last slot");

    // elements of one block leave in slot order
    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_sent && !o_run_end) |=> (empty || (o_sent
            && o_sent_slot == $past(o_sent_slot) + 1'b1
            && o_sent_block == $past(o_sent_block)
            && o_next_nonzero_block == $past(o_next_nonzero_block))))
        else $error("block elements out of order");

    // first cycle out of reset shows no results
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> empty)
        else $error("results present after reset");
endmodule

bind sparse_block_gradient_worker sbgw_checker #(.BLOCK_SIZE(BLOCK_SIZE)) u_sbgw_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .empty                (empty),
    .pop                  (pop),
    .o_sent               (o_sent),
    .o_sender             (o_sender),
    .o_sent_block         (o_sent_block),
    .o_sent_slot          (o_sent_slot),
    .o_sent_bits          (o_sent_bits),
    .o_next_nonzero_block (o_next_nonzero_block),
    .o_run_end            (o_run_end)
);
